@@ src/tgc_pkg.sv @@
// Shared types and constants for the tilt gesture classifier.
package tgc_pkg;

  localparam int AccelW = 16;
  localparam int ThrW   = 15;
  localparam int MapW   = 4;
  localparam int ClsW   = 3;
  localparam int CfgIdxW = 2;

  typedef logic [ClsW-1:0] cls_t;

  localparam cls_t CLS_NONE    = 3'd0;
  localparam cls_t CLS_LEFT    = 3'd1;
  localparam cls_t CLS_RIGHT   = 3'd2;
  localparam cls_t CLS_SHAKE   = 3'd3;
  localparam cls_t CLS_UP      = 3'd4;
  localparam cls_t CLS_DOWN    = 3'd5;
  localparam cls_t CLS_FORWARD = 3'd6;
  localparam cls_t CLS_BACK    = 3'd7;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_AXIS_MAP  = 2'd0;
  localparam cfg_idx_t CFG_TURN_THR  = 2'd1;
  localparam cfg_idx_t CFG_TILT_THR  = 2'd2;
  localparam cfg_idx_t CFG_SHAKE_THR = 2'd3;

  localparam logic [ThrW-1:0] TURN_THR_RST  = 15'd4000;
  localparam logic [ThrW-1:0] TILT_THR_RST  = 15'd5000;
  localparam logic [ThrW-1:0] SHAKE_THR_RST = 15'd1000;

  // axis_map bits
  localparam int MapInvX = 0;
  localparam int MapInvY = 1;
  localparam int MapSwap = 3;

  // classified word passed from front to back
  typedef struct packed {
    cls_t cls;
    logic ack;
  } item_t;

  // handshake between stages
  typedef struct packed {
    logic  valid;
    item_t item;
  } link_t;

endpackage

@@ src/tilt_gesture_classifier.sv @@
// A word accepted by the front passes through the front register, the queue and the
// result register before it shows on the out_ ports. One word per cycle is taken while
// in_stall is low; the two-entry queue lets front and back stall apart.
// Reset (rst_n low, synchronous) empties the pipeline, clears class history and
// the pending action, and loads the threshold registers with their default values.
module tilt_gesture_classifier (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  tgc_pkg::cfg_idx_t         cfg_index,
  input  logic [tgc_pkg::ThrW-1:0]  cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [tgc_pkg::AccelW-1:0] in_accel_x,
  input  logic signed [tgc_pkg::AccelW-1:0] in_accel_y,
  input  logic                      in_ack_pending,
  output logic                      out_valid,
  input  logic                      out_stall,
  output tgc_pkg::cls_t             out_sample_class,
  output logic                      out_action_valid,
  output tgc_pkg::cls_t             out_action_code
);
  import tgc_pkg::*;

  link_t fr_link, q_link;
  logic  fr_stall, q_stall;

  tgc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_accel_x    (in_accel_x),
    .in_accel_y    (in_accel_y),
    .in_ack_pending(in_ack_pending),
    .fr_out        (fr_link),
    .fr_stall      (fr_stall)
  );

  tgc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_in   (fr_link),
    .push_stall(fr_stall),
    .pop_out   (q_link),
    .pop_stall (q_stall)
  );

  tgc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .bk_in           (q_link),
    .bk_stall        (q_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample_class(out_sample_class),
    .out_action_valid(out_action_valid),
    .out_action_code (out_action_code)
  );

endmodule

@@ src/tgc_front.sv @@
// Front end: configuration registers, axis remap and sample classification.
module tgc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  tgc_pkg::cfg_idx_t             cfg_index,
  input  logic [tgc_pkg::ThrW-1:0]      cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [tgc_pkg::AccelW-1:0] in_accel_x,
  input  logic signed [tgc_pkg::AccelW-1:0] in_accel_y,
  input  logic                          in_ack_pending,
  output tgc_pkg::link_t                fr_out,
  input  logic                          fr_stall
);
  import tgc_pkg::*;

  logic [MapW-1:0] axis_map_r;
  logic [ThrW-1:0] turn_thr_r, tilt_thr_r, shake_thr_r;

  logic signed [AccelW-1:0] xi, yi, xm, ym;
  logic signed [AccelW:0]   xe, ye, turn_p, turn_n, tilt_p, tilt_n, shake_p, shake_n;
  cls_t  cls;
  logic  accept;
  logic  fr_valid_r;
  item_t fr_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_map_r  <= '0;
      turn_thr_r  <= TURN_THR_RST;
      tilt_thr_r  <= TILT_THR_RST;
      shake_thr_r <= SHAKE_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AXIS_MAP:  axis_map_r  <= cfg_wdata[MapW-1:0];
        CFG_TURN_THR:  turn_thr_r  <= cfg_wdata;
        CFG_TILT_THR:  tilt_thr_r  <= cfg_wdata;
        CFG_SHAKE_THR: shake_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    // negation wraps in 16 bits, so the most negative value maps to itself
    xi = axis_map_r[MapInvX] ? -in_accel_x : in_accel_x;
    yi = axis_map_r[MapInvY] ? -in_accel_y : in_accel_y;
    xm = axis_map_r[MapSwap] ? yi : xi;
    ym = axis_map_r[MapSwap] ? xi : yi;

    xe = {xm[AccelW-1], xm};
    ye = {ym[AccelW-1], ym};
    turn_p  = $signed({2'b00, turn_thr_r});
    tilt_p  = $signed({2'b00, tilt_thr_r});
    shake_p = $signed({2'b00, shake_thr_r});
    turn_n  = -turn_p;
    tilt_n  = -tilt_p;
    shake_n = -shake_p;

    if (ye > turn_p)                       cls = CLS_LEFT;
    else if (ye < turn_n)                  cls = CLS_RIGHT;
    else if (ye > shake_p || ye < shake_n) cls = CLS_SHAKE;
    else if (xe > tilt_p)                  cls = CLS_UP;
    else if (xe < tilt_n)                  cls = CLS_DOWN;
    else if (xe > shake_p || xe < shake_n) cls = CLS_SHAKE;
    else                                   cls = CLS_NONE;
  end

  assign in_stall = fr_valid_r & fr_stall;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (accept) begin
      fr_valid_r <= 1'b1;
    end else if (!fr_stall) begin
      fr_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_item_r.cls <= cls;
      fr_item_r.ack <= in_ack_pending;
    end
  end

  assign fr_out.valid = fr_valid_r;
  assign fr_out.item  = fr_item_r;

endmodule

@@ src/tgc_queue.sv @@
// Two-entry queue between the classifier front and the action back end.
module tgc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  tgc_pkg::link_t push_in,
  output logic           push_stall,
  output tgc_pkg::link_t pop_out,
  input  logic           pop_stall
);
  import tgc_pkg::*;

  item_t      mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       push, pop;

  assign push_stall = count_r[1];
  assign push = push_in.valid & ~count_r[1];
  assign pop  = (count_r != 2'd0) & ~pop_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_in.item;
  end

  assign pop_out.valid = (count_r != 2'd0);
  assign pop_out.item  = mem[rd_ptr_r];

endmodule

@@ src/tgc_back.sv @@
// Back end: class history, pending action tracking and result register.
module tgc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  tgc_pkg::link_t bk_in,
  output logic           bk_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output tgc_pkg::cls_t  out_sample_class,
  output logic           out_action_valid,
  output tgc_pkg::cls_t  out_action_code
);
  import tgc_pkg::*;

  cls_t prev_one_r, prev_two_r, pend_code_r;
  logic pend_flag_r;
  cls_t prev_one_nxt, prev_two_nxt, pend_code_nxt;
  logic pend_flag_nxt;
  logic hold;
  logic out_valid_r, act_valid_r;
  cls_t cls_r, act_code_r;
  logic take;
  cls_t cls;

  assign bk_stall = out_valid_r & out_stall;
  assign take     = bk_in.valid & ~bk_stall;
  assign cls      = bk_in.item.cls;

  always_comb begin
    pend_flag_nxt = bk_in.item.ack ? 1'b0 : pend_flag_r;
    pend_code_nxt = bk_in.item.ack ? CLS_NONE : pend_code_r;
    hold = 1'b0;
    if (!pend_flag_nxt) begin
      if (cls != CLS_NONE) begin
        pend_flag_nxt = 1'b1;
        pend_code_nxt = cls;
      end
      // three up (or down) in a row promote to forward (or back) when no action is pending
      if ((cls inside {CLS_UP, CLS_DOWN}) && prev_one_r == cls && prev_two_r == cls) begin
        hold          = 1'b1;
        pend_code_nxt = (cls == CLS_UP) ? CLS_FORWARD : CLS_BACK;
      end
    end
    prev_two_nxt = hold ? CLS_NONE : prev_one_r;
    prev_one_nxt = cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_one_r  <= CLS_NONE;
      prev_two_r  <= CLS_NONE;
      pend_flag_r <= 1'b0;
      pend_code_r <= CLS_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        prev_one_r  <= prev_one_nxt;
        prev_two_r  <= prev_two_nxt;
        pend_flag_r <= pend_flag_nxt;
        pend_code_r <= pend_code_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cls_r       <= cls;
      act_valid_r <= pend_flag_nxt;
      act_code_r  <= pend_flag_nxt ? pend_code_nxt : CLS_NONE;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_class = cls_r;
  assign out_action_valid = act_valid_r;
  assign out_action_code  = act_code_r;

endmodule

@@ test/tb_top.sv @@
// Testbench for tilt_gesture_classifier: directed and random samples checked against a predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tgc_pkg::*;

  localparam int LimitCycles = 400000;

  typedef logic signed [AccelW-1:0] accel_t;
  typedef logic [ThrW-1:0] thr_t;

  typedef struct {
    accel_t x;
    accel_t y;
    logic   ack;
  } sample_t;

  typedef struct {
    cls_t cls;
    logic act_valid;
    cls_t act_code;
  } gesture_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_AXIS_MAP;
  thr_t     cfg_wdata = '0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  accel_t   in_accel_x = '0;
  accel_t   in_accel_y = '0;
  logic     in_ack_pending = 1'b0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cls_t     out_sample_class;
  logic     out_action_valid;
  cls_t     out_action_code;

  tilt_gesture_classifier dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_accel_x       (in_accel_x),
    .in_accel_y       (in_accel_y),
    .in_ack_pending   (in_ack_pending),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_class (out_sample_class),
    .out_action_valid (out_action_valid),
    .out_action_code  (out_action_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of registers and gesture state
  logic [MapW-1:0] model_map = '0;
  thr_t model_turn  = TURN_THR_RST;
  thr_t model_tilt  = TILT_THR_RST;
  thr_t model_shake = SHAKE_THR_RST;
  cls_t hist_one = CLS_NONE;
  cls_t hist_two = CLS_NONE;
  logic held_flag = 1'b0;
  cls_t held_code = CLS_NONE;

  sample_t  sample_fifo[$];
  gesture_t expected_gestures[$];
  int queued_cnt = 0;
  int taken_cnt = 0;
  int err_cnt = 0;

  function automatic accel_t flip(accel_t v, logic en);
    // negation wraps, so the most negative value maps to itself
    return en ? accel_t'(-v) : v;
  endfunction

  function automatic cls_t classify_tilt(int x, int y);
    int turn, tilt, shake;
    turn  = int'(model_turn);
    tilt  = int'(model_tilt);
    shake = int'(model_shake);
    if (y > turn) return CLS_LEFT;
    if (y < -turn) return CLS_RIGHT;
    if (y > shake || y < -shake) return CLS_SHAKE;
    if (x > tilt) return CLS_UP;
    if (x < -tilt) return CLS_DOWN;
    if (x > shake || x < -shake) return CLS_SHAKE;
    return CLS_NONE;
  endfunction

  function automatic void track_sample(sample_t s);
    accel_t   xi, yi, xm, ym;
    cls_t     c;
    gesture_t g;
    if (s.ack) begin
      held_flag = 1'b0;
      held_code = CLS_NONE;
    end
    xi = flip(s.x, model_map[MapInvX]);
    yi = flip(s.y, model_map[MapInvY]);
    xm = model_map[MapSwap] ? yi : xi;
    ym = model_map[MapSwap] ? xi : yi;
    c = classify_tilt(xm, ym);
    if (!held_flag) begin
      if (c != CLS_NONE) begin
        held_flag = 1'b1;
        held_code = c;
      end
      // three up or down in a row: forward or back, older history entry cleared
      if ((c == CLS_UP || c == CLS_DOWN) && hist_one == c && hist_two == c) begin
        held_code = (c == CLS_UP) ? CLS_FORWARD : CLS_BACK;
        hist_one = CLS_NONE;
      end
    end
    hist_two = hist_one;
    hist_one = c;
    g.cls = c;
    g.act_valid = held_flag;
    g.act_code = held_flag ? held_code : CLS_NONE;
    expected_gestures.push_back(g);
  endfunction

  // sender: bursts of words with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    sample_t taken, nxt;
    if (in_valid && !in_stall) begin
      taken.x = in_accel_x;
      taken.y = in_accel_y;
      taken.ack = in_ack_pending;
      track_sample(taken);
      taken_cnt++;
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (sample_fifo.size() > 0) begin
        nxt = sample_fifo.pop_front();
        in_valid <= 1'b1;
        in_accel_x <= nxt.x;
        in_accel_y <= nxt.y;
        in_ack_pending <= nxt.ack;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with a periodic long hold-off while words are offered
  int stall_cyc = 0;
  int hold_left = 0;
  int next_hold = 400;
  int stall_mode = 0;

  always @(posedge clk) begin
    stall_cyc++;
    if (hold_left == 0 && stall_cyc >= next_hold && in_valid) begin
      hold_left = $urandom_range(30, 60);
      next_hold = stall_cyc + 1500;
    end
    if (stall_cyc % 64 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_cyc[0];
      endcase
    end
  end

  always @(posedge clk) begin
    gesture_t g;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_gestures.size() == 0) begin
        $error("unexpected word: sample_class %0d", out_sample_class);
        err_cnt++;
      end else begin
        g = expected_gestures.pop_front();
        if (out_sample_class !== g.cls) begin
          $error("sample_class: expected %0d, got %0d", g.cls, out_sample_class);
          err_cnt++;
        end
        if (out_action_valid !== g.act_valid) begin
          $error("action_valid: expected %0d, got %0d", g.act_valid, out_action_valid);
          err_cnt++;
        end
        if (out_action_code !== g.act_code) begin
          $error("action_code: expected %0d, got %0d", g.act_code, out_action_code);
          err_cnt++;
        end
      end
    end
  end

  int timeout_cyc = 0;

  always @(posedge clk) begin
    timeout_cyc++;
    if (timeout_cyc == LimitCycles) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void add_sample(int x, int y, logic ack);
    sample_t s;
    s.x = accel_t'(x);
    s.y = accel_t'(y);
    s.ack = ack;
    sample_fifo.push_back(s);
    queued_cnt++;
  endfunction

  // takes the axes as the classifier sees them and undoes swap and inversion
  function automatic void add_mapped(int xm, int ym, logic ack);
    accel_t xi, yi;
    xi = accel_t'(model_map[MapSwap] ? ym : xm);
    yi = accel_t'(model_map[MapSwap] ? xm : ym);
    add_sample(flip(xi, model_map[MapInvX]), flip(yi, model_map[MapInvY]), ack);
  endfunction

  function automatic int quiet_value();
    int q, v;
    q = (model_turn < model_shake) ? int'(model_turn) : int'(model_shake);
    v = $urandom_range(0, q);
    return $urandom_range(0, 1) ? v : -v;
  endfunction

  function automatic int tilt_value(bit down);
    int t;
    t = int'(model_tilt);
    if (down) return -int'($urandom_range(t + 1, 32768));
    if (t == 32767) return 32767;
    return $urandom_range(t + 1, 32767);
  endfunction

  function automatic int corner_value();
    int t;
    case ($urandom_range(0, 2))
      0: t = int'(model_turn);
      1: t = int'(model_tilt);
      default: t = int'(model_shake);
    endcase
    case ($urandom_range(0, 6))
      0: return 0;
      1: return t;
      2: return t + 1;
      3: return -t;
      4: return -t - 1;
      5: return 32767;
      default: return -32768;
    endcase
  endfunction

  task automatic program_regs(logic [MapW-1:0] map, thr_t turn, thr_t tilt, thr_t shake);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_AXIS_MAP;
    cfg_wdata <= thr_t'(map);
    @(posedge clk);
    cfg_index <= CFG_TURN_THR;
    cfg_wdata <= turn;
    @(posedge clk);
    cfg_index <= CFG_TILT_THR;
    cfg_wdata <= tilt;
    @(posedge clk);
    cfg_index <= CFG_SHAKE_THR;
    cfg_wdata <= shake;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_map = map;
    model_turn = turn;
    model_tilt = tilt;
    model_shake = shake;
  endtask

  task automatic drain();
    while (taken_cnt != queued_cnt || expected_gestures.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int target, len;
    bit down;
    logic [MapW-1:0] map;
    thr_t turn, tilt, shake;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset thresholds: turn 4000, tilt 5000, shake 1000, no remap
    add_sample(0, 0, 1'b0);
    add_sample(0, 4001, 1'b0);
    add_sample(0, -4001, 1'b1);
    add_sample(5001, 4000, 1'b0);       // y shake wins over x up
    add_sample(1000, -1000, 1'b1);      // thresholds are strict
    add_sample(1001, 0, 1'b0);
    add_sample(-1001, 0, 1'b1);
    add_sample(32767, 32767, 1'b1);
    add_sample(-32768, -32768, 1'b1);
    add_sample(5000, 0, 1'b1);
    add_sample(5001, 0, 1'b1);
    add_sample(32767, 0, 1'b1);
    add_sample(5001, -1000, 1'b1);      // third up: forward
    add_sample(5001, 0, 1'b0);          // pending, history still fills
    add_sample(5001, 0, 1'b1);          // forward again
    add_sample(-5001, 0, 1'b1);
    add_sample(-32768, 0, 1'b0);
    add_sample(-32768, 1000, 1'b0);
    add_sample(-5001, 0, 1'b1);         // back
    add_sample(0, -1001, 1'b0);
    add_sample(0, 0, 1'b1);
    drain();

    // invert both axes and swap; most negative value wraps to itself
    program_regs(4'b1011, TURN_THR_RST, TILT_THR_RST, SHAKE_THR_RST);
    add_sample(-32768, 0, 1'b1);
    add_sample(0, 5001, 1'b1);
    add_sample(100, 0, 1'b1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          map = 4'b0100;
          turn = TURN_THR_RST;
          tilt = TILT_THR_RST;
          shake = SHAKE_THR_RST;
        end
        1: begin
          map = 4'b1111;
          turn = '0;
          tilt = '0;
          shake = '0;
        end
        2: begin
          map = MapW'($urandom_range(0, 15));
          turn = '1;
          tilt = '1;
          shake = '1;
        end
        default: begin
          map = MapW'($urandom_range(0, 15));
          turn = thr_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                     : $urandom_range(0, 8000));
          tilt = thr_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                     : $urandom_range(0, 8000));
          shake = thr_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                      : $urandom_range(0, 4000));
        end
      endcase
      program_regs(map, turn, tilt, shake);
      target = queued_cnt + 92;
      while (queued_cnt < target) begin
        if ($urandom_range(0, 9) < 6) begin
          // run of tilts in one direction; ack on the last word lets a hold fire
          down = $urandom_range(0, 1);
          len = $urandom_range(2, 5);
          for (int k = 0; k < len; k++) begin
            add_mapped(tilt_value(down), quiet_value(),
                       (k == len - 1) ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 3) == 0));
          end
        end else begin
          len = $urandom_range(1, 4);
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 1))
              add_sample(int'(accel_t'($urandom)), int'(accel_t'($urandom)),
                         $urandom_range(0, 3) == 0);
            else
              add_mapped(corner_value(), corner_value(), $urandom_range(0, 3) == 0);
          end
        end
      end
      drain();
    end

    if (err_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
src/tgc_pkg.sv
src/tgc_front.sv
src/tgc_queue.sv
src/tgc_back.sv
src/tilt_gesture_classifier.sv
test/tb_top.sv
